### hdl/rrcg_pkg.sv
// Shared types, constants and helpers for the radial raised-cosine gain block.
package rrcg_pkg;

  localparam int MAX_SIDE  = 512;
  localparam int HALF_SIDE = MAX_SIDE / 2;
  localparam int ADDR_W    = $clog2(HALF_SIDE);
  localparam int CNT_W     = $clog2(MAX_SIDE);
  localparam int SIDE_W    = CNT_W + 1;
  localparam int LOG_MAX   = $clog2(MAX_SIDE);
  localparam int NUM_TERMS = 11;

  localparam logic [1:0] REG_GAIN_LOW  = 2'd0;
  localparam logic [1:0] REG_GAIN_HIGH = 2'd1;
  localparam logic [1:0] REG_CUTOFF    = 2'd2;
  localparam logic [1:0] REG_SIZE_LOG2 = 2'd3;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic        start;
    logic        abort;
    alu_op_t     op;
    logic [63:0] opa;
    logic [31:0] opb;
  } alu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  // Taylor term divisor (2k-1)(2k)
  function automatic logic [15:0] term_div(input logic [3:0] k);
    logic [15:0] d;
    case (k)
      4'd1:    d = 16'd2;
      4'd2:    d = 16'd12;
      4'd3:    d = 16'd30;
      4'd4:    d = 16'd56;
      4'd5:    d = 16'd90;
      4'd6:    d = 16'd132;
      4'd7:    d = 16'd182;
      4'd8:    d = 16'd240;
      4'd9:    d = 16'd306;
      4'd10:   d = 16'd380;
      4'd11:   d = 16'd462;
      default: d = 16'd1;
    endcase
    return d;
  endfunction

endpackage

### hdl/rrcg_alu.sv
// Shared bit-serial unit: 32x32 shift-add multiply and 64/16 restoring divide.
module rrcg_alu
  import rrcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  alu_cmd_t    cmd,
  output alu_stat_t   stat,
  output logic [63:0] result
);

  logic [63:0] acc_r, acc_nxt;
  logic [31:0] opb_r, opb_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  alu_op_t     op_r, op_nxt;

  logic [32:0] msum;
  logic [16:0] rem2;
  logic        ge;

  always_comb begin
    msum = {1'b0, acc_r[63:32]} + (acc_r[0] ? {1'b0, opb_r} : 33'd0);
    rem2 = {rem_r, acc_r[63]};
    ge   = rem2 >= {1'b0, opb_r[15:0]};

    acc_nxt  = acc_r;
    opb_nxt  = opb_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;

    if (cmd.abort) begin
      busy_nxt = 1'b0;
    end else if (cmd.start) begin
      op_nxt   = cmd.op;
      opb_nxt  = cmd.opb;
      rem_nxt  = '0;
      busy_nxt = 1'b1;
      if (cmd.op == ALU_MUL) begin
        acc_nxt = {32'd0, cmd.opa[31:0]};
        cnt_nxt = 6'd31;
      end else begin
        acc_nxt = cmd.opa;
        cnt_nxt = 6'd63;
      end
    end else if (busy_r) begin
      if (op_r == ALU_MUL) begin
        acc_nxt = {msum, acc_r[31:1]};
      end else begin
        rem_nxt = ge ? 16'(rem2 - {1'b0, opb_r[15:0]}) : rem2[15:0];
        acc_nxt = {acc_r[62:0], ge};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    opb_r <= opb_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    op_r  <= op_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign stat   = '{busy: busy_r, done: done_r};
  assign result = acc_r;

endmodule

### hdl/radial_raised_cosine_spectrum_gain.sv
// Radial raised-cosine gain over a centered N x N spectrum frame, raster order.
// After reset, and after any write to gain_low, gain_high or cutoff_radius, the
// block rebuilds its radial gain table and holds in_tready low until done: each
// entry up to the cutoff (at most 256 entries) takes one theta divide, one square
// and eleven Taylor steps of multiply and divide, all through the one shared
// bit-serial multiplier / divider. Once the table is ready, a coefficient passes
// through the accept, nine integer square-root digits, a table read, two gain
// multiplies and the output load, which waits while the output register still
// holds a beat that the sink has not taken.
// A finished beat waits in the output register while the next item is taken.
module radial_raised_cosine_spectrum_gain
  import rrcg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // coef_re [31:0], coef_im [63:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // out_re [31:0], out_im [63:32]
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  typedef enum logic [2:0] {
    B_IDLE, B_THETA, B_THW, B_TH2W, B_TMW, B_TDW, B_GAIN
  } build_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SQRT, S_RD, S_MRE, S_MIM, S_FIN
  } item_t;

  // configuration
  logic [15:0] gain_low_r, gain_high_r;
  logic [8:0]  cutoff_r;
  logic [3:0]  size_log2_r;

  // table build
  build_t             bstate_r, bstate_nxt;
  logic               ready_r, ready_nxt;
  logic [ADDR_W-1:0]  x_r, x_nxt;
  logic [31:0]        th2_r, th2_nxt;
  logic [31:0]        term_r, term_nxt;
  logic signed [35:0] sum_r, sum_nxt;
  logic [3:0]         k_r, k_nxt;

  logic [15:0] gain_mem [HALF_SIDE];
  logic              mem_we;
  logic [15:0]       mem_wdata;
  logic [15:0]       mem_rdata_r;

  alu_cmd_t    cmd;
  alu_stat_t   stat;
  logic [63:0] alu_res;

  // item path
  item_t            istate_r, istate_nxt;
  logic [CNT_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [31:0]      re_r, re_nxt, im_r, im_nxt;
  logic             last_r, last_nxt;
  logic [17:0]      sv_r, sv_nxt, sres_r, sres_nxt, sbit_r, sbit_nxt;
  logic [ADDR_W-1:0] raddr;
  logic [47:0]      prod_r, prod_nxt;
  logic             pneg_r, pneg_nxt;
  logic [31:0]      ore_r, ore_nxt, oim_r, oim_nxt;
  logic             olast_r, olast_nxt;
  logic             ovalid_r, ovalid_nxt;

  logic [8:0]        cut_eff;
  logic [ADDR_W-1:0] last_x;
  logic [15:0]       den;
  logic [3:0]        s_eff;
  logic [SIDE_W-1:0] side, half;
  logic              cfg_tbl;

  function automatic logic [32:0] mag_of(input logic [31:0] v);
    return v[31] ? 33'(~{1'b0, v} + 33'd1) : {1'b0, v};
  endfunction

  function automatic logic [31:0] sat_out(input logic [47:0] p, input logic neg);
    logic [36:0] r;
    r = 37'((p + 48'd2048) >> 12);
    if (neg) begin
      if (r > 37'h080000000) r = 37'h080000000;
      return 32'(~r + 37'd1);
    end
    if (r > 37'h07FFFFFFF) r = 37'h07FFFFFFF;
    return r[31:0];
  endfunction

  rrcg_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .result (alu_res)
  );

  assign cut_eff = (cutoff_r == 9'd0) ? 9'd1 : cutoff_r;
  assign last_x  = (cut_eff >= 9'(HALF_SIDE - 1)) ? ADDR_W'(HALF_SIDE - 1)
                                                  : cut_eff[ADDR_W-1:0];
  assign den     = 16'(cut_eff * 7'd100);
  assign s_eff   = (size_log2_r == 4'd0) ? 4'd1 :
                   (size_log2_r > 4'(LOG_MAX)) ? 4'(LOG_MAX) : size_log2_r;
  assign side    = SIDE_W'(1) << s_eff;
  assign half    = side >> 1;
  assign cfg_tbl = cfg_we && (cfg_addr == REG_GAIN_LOW || cfg_addr == REG_GAIN_HIGH ||
                              cfg_addr == REG_CUTOFF);

  // table build sequencer
  always_comb begin
    logic signed [35:0] s2;
    logic [22:0]        rr;
    logic signed [24:0] c;
    logic [16:0]        w;
    logic [15:0]        diff;
    logic [32:0]        dw;
    logic [17:0]        g;

    bstate_nxt = bstate_r;
    ready_nxt  = ready_r;
    x_nxt      = x_r;
    th2_nxt    = th2_r;
    term_nxt   = term_r;
    sum_nxt    = sum_r;
    k_nxt      = k_r;
    cmd        = '{start: 1'b0, abort: 1'b0, op: ALU_MUL, opa: '0, opb: '0};
    mem_we     = 1'b0;

    s2   = sum_r + 36'sd536870912;
    if (s2 < 0) s2 = '0;
    rr   = 23'((s2 + 36'sd4096) >>> 13);
    c    = 25'($signed({2'b0, rr}) - 25'sd65536);
    if (c > 25'sd32767) c = 25'sd32767;
    if (c < -25'sd32768) c = -25'sd32768;
    w    = 17'(25'sd32768 - c);
    diff = (gain_high_r > gain_low_r) ? 16'(gain_high_r - gain_low_r) : 16'd0;
    dw   = diff * w;
    g    = {2'b0, gain_low_r} + 18'((dw + 33'd32768) >> 16);
    mem_wdata = (g > 18'h0FFFF) ? 16'hFFFF : g[15:0];

    case (bstate_r)
      B_IDLE: begin
        if (!ready_r) begin
          x_nxt      = '0;
          bstate_nxt = B_THETA;
        end
      end
      B_THETA: begin
        cmd.start  = 1'b1;
        cmd.op     = ALU_DIV;
        cmd.opa    = 64'(({28'd0, 17'(x_r * 9'd314)} << 28) + 45'(den >> 1));
        cmd.opb    = 32'(den);
        bstate_nxt = B_THW;
      end
      B_THW: begin
        if (stat.done) begin
          cmd.start  = 1'b1;
          cmd.op     = ALU_MUL;
          cmd.opa    = {32'd0, alu_res[31:0]};
          cmd.opb    = alu_res[31:0];
          bstate_nxt = B_TH2W;
        end
      end
      B_TH2W: begin
        if (stat.done) begin
          th2_nxt    = alu_res[59:28];
          term_nxt   = 32'h10000000;
          sum_nxt    = 36'sd268435456;
          k_nxt      = 4'd1;
          cmd.start  = 1'b1;
          cmd.op     = ALU_MUL;
          cmd.opa    = 64'h10000000;
          cmd.opb    = alu_res[59:28];
          bstate_nxt = B_TMW;
        end
      end
      B_TMW: begin
        if (stat.done) begin
          cmd.start  = 1'b1;
          cmd.op     = ALU_DIV;
          cmd.opa    = {28'd0, alu_res[63:28]};
          cmd.opb    = {16'd0, term_div(k_r)};
          bstate_nxt = B_TDW;
        end
      end
      B_TDW: begin
        if (stat.done) begin
          term_nxt = alu_res[31:0];
          if (k_r[0]) sum_nxt = sum_r - $signed({4'd0, alu_res[31:0]});
          else        sum_nxt = sum_r + $signed({4'd0, alu_res[31:0]});
          if (k_r == 4'(NUM_TERMS)) begin
            bstate_nxt = B_GAIN;
          end else begin
            k_nxt      = k_r + 4'd1;
            cmd.start  = 1'b1;
            cmd.op     = ALU_MUL;
            cmd.opa    = {32'd0, alu_res[31:0]};
            cmd.opb    = th2_r;
            bstate_nxt = B_TMW;
          end
        end
      end
      B_GAIN: begin
        mem_we = 1'b1;
        if (x_r == last_x) begin
          ready_nxt  = 1'b1;
          bstate_nxt = B_IDLE;
        end else begin
          x_nxt      = x_r + ADDR_W'(1);
          bstate_nxt = B_THETA;
        end
      end
      default: bstate_nxt = B_IDLE;
    endcase

    // restart on a gain or cutoff write
    if (cfg_tbl) begin
      cmd.start  = 1'b0;
      cmd.abort  = 1'b1;
      mem_we     = 1'b0;
      ready_nxt  = 1'b0;
      x_nxt      = '0;
      bstate_nxt = B_THETA;
    end
  end

  // per-coefficient sequencer
  always_comb begin
    logic [SIDE_W-1:0] dx, dy;
    logic [18:0]       trial;
    logic [SIDE_W-1:0] halfm1;
    logic [ADDR_W-1:0] rad;
    logic [32:0]       mag;

    istate_nxt = istate_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    re_nxt     = re_r;
    im_nxt     = im_r;
    last_nxt   = last_r;
    sv_nxt     = sv_r;
    sres_nxt   = sres_r;
    sbit_nxt   = sbit_r;
    prod_nxt   = prod_r;
    pneg_nxt   = pneg_r;
    ore_nxt    = ore_r;
    oim_nxt    = oim_r;
    olast_nxt  = olast_r;
    ovalid_nxt = ovalid_r && !out_tready;
    in_tready  = (istate_r == S_IDLE) && ready_r;

    dx = ({1'b0, col_r} >= half) ? {1'b0, col_r} - half : half - {1'b0, col_r};
    dy = ({1'b0, row_r} >= half) ? {1'b0, row_r} - half : half - {1'b0, row_r};
    trial  = {1'b0, sres_r} + {1'b0, sbit_r};
    halfm1 = half - SIDE_W'(1);
    rad    = ({1'b0, sres_r} > 19'(halfm1)) ? halfm1[ADDR_W-1:0] : sres_r[ADDR_W-1:0];
    raddr  = ({1'b0, rad} > cut_eff) ? cut_eff[ADDR_W-1:0] : rad;
    mag    = '0;

    case (istate_r)
      S_IDLE: begin
        if (in_tvalid && ready_r) begin
          re_nxt   = in_tdata[31:0];
          im_nxt   = in_tdata[63:32];
          sv_nxt   = 18'(dx * dx) + 18'(dy * dy);
          sres_nxt = '0;
          sbit_nxt = 18'h10000;
          last_nxt = ({1'b0, col_r} == side - SIDE_W'(1)) &&
                     ({1'b0, row_r} == side - SIDE_W'(1));
          if ({1'b0, col_r} + SIDE_W'(1) >= side) begin
            col_nxt = '0;
            row_nxt = ({1'b0, row_r} + SIDE_W'(1) >= side) ? '0 : row_r + CNT_W'(1);
          end else begin
            col_nxt = col_r + CNT_W'(1);
          end
          istate_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if ({1'b0, sv_r} >= trial) begin
          sv_nxt   = 18'({1'b0, sv_r} - trial);
          sres_nxt = (sres_r >> 1) + sbit_r;
        end else begin
          sres_nxt = sres_r >> 1;
        end
        sbit_nxt = sbit_r >> 2;
        if (sbit_r[0]) istate_nxt = S_RD;
      end
      S_RD: begin
        istate_nxt = S_MRE;
      end
      S_MRE: begin
        mag        = mag_of(re_r);
        prod_nxt   = mag[31:0] * mem_rdata_r;
        pneg_nxt   = re_r[31];
        istate_nxt = S_MIM;
      end
      S_MIM: begin
        // park the scaled real part; the output register may still hold a beat
        mag        = mag_of(im_r);
        re_nxt     = sat_out(prod_r, pneg_r);
        prod_nxt   = mag[31:0] * mem_rdata_r;
        pneg_nxt   = im_r[31];
        istate_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!ovalid_r || out_tready) begin
          ore_nxt    = re_r;
          oim_nxt    = sat_out(prod_r, pneg_r);
          olast_nxt  = last_r;
          ovalid_nxt = 1'b1;
          istate_nxt = S_IDLE;
        end
      end
      default: istate_nxt = S_IDLE;
    endcase

    if (cfg_we && cfg_addr == REG_SIZE_LOG2) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) gain_mem[x_r] <= mem_wdata;
    mem_rdata_r <= gain_mem[raddr];
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    th2_r  <= th2_nxt;
    term_r <= term_nxt;
    sum_r  <= sum_nxt;
    k_r    <= k_nxt;
    re_r   <= re_nxt;
    im_r   <= im_nxt;
    last_r <= last_nxt;
    sv_r   <= sv_nxt;
    sres_r <= sres_nxt;
    sbit_r <= sbit_nxt;
    prod_r <= prod_nxt;
    pneg_r <= pneg_nxt;
    ore_r  <= ore_nxt;
    oim_r  <= oim_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      bstate_r    <= B_IDLE;
      ready_r     <= 1'b0;
      istate_r    <= S_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      ovalid_r    <= 1'b0;
      gain_low_r  <= 16'd2048;
      gain_high_r <= 16'd8192;
      cutoff_r    <= 9'd32;
      size_log2_r <= 4'd8;
    end else begin
      bstate_r <= bstate_nxt;
      ready_r  <= ready_nxt;
      istate_r <= istate_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          REG_GAIN_LOW:  gain_low_r  <= cfg_wdata;
          REG_GAIN_HIGH: gain_high_r <= cfg_wdata;
          REG_CUTOFF:    cutoff_r    <= cfg_wdata[8:0];
          REG_SIZE_LOG2: size_log2_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {oim_r, ore_r};
  assign out_tlast  = olast_r;

endmodule

### test/tb_radial_raised_cosine_spectrum_gain.sv
// Testbench for the radial raised-cosine spectrum gain block, with its own scoreboard.
`timescale 1ns / 1ps

module tb_radial_raised_cosine_spectrum_gain;
  import rrcg_pkg::*;

  typedef struct {
    logic [31:0] re;
    logic [31:0] im;
    logic        last;
  } scaled_coef_t;

  class gain_scoreboard;
    int unsigned gain_lo, gain_hi, cutoff, side_log2;
    int unsigned col, row;
    logic [15:0] gain_lut [HALF_SIDE];
    bit          lut_valid;
    scaled_coef_t pending [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned frames;

    function new();
      gain_lo = 2048;
      gain_hi = 8192;
      cutoff = 32;
      side_log2 = 8;
      col = 0;
      row = 0;
      lut_valid = 0;
      errors = 0;
      checked = 0;
      frames = 0;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %0s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function void write_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        REG_GAIN_LOW:  begin gain_lo = val; lut_valid = 0; end
        REG_GAIN_HIGH: begin gain_hi = val; lut_valid = 0; end
        REG_CUTOFF:    begin cutoff = val[8:0]; lut_valid = 0; end
        REG_SIZE_LOG2: begin side_log2 = val[3:0]; col = 0; row = 0; end
        default: ;
      endcase
    endfunction

    function int cosine_q15(int unsigned r, int unsigned cut);
      longint unsigned den, th, th2, term, rr;
      longint sum;
      int c;
      den = 100 * longint'(cut);
      th = (((longint'(r) * 314) << 28) + den / 2) / den;
      th2 = (th * th) >> 28;
      term = 64'd1 << 28;
      sum = term;
      for (int k = 1; k <= 11; k++) begin
        term = ((term * th2) >> 28) / ((2 * k - 1) * (2 * k));
        if (k % 2) sum -= term;
        else sum += term;
      end
      sum += 64'sd1 << 29;
      if (sum < 0) sum = 0;
      rr = (sum + 4096) >> 13;
      c = int'(rr) - 65536;
      if (c > 32767) c = 32767;
      if (c < -32768) c = -32768;
      return c;
    endfunction

    function void build_lut();
      int unsigned diff, cut, w;
      longint unsigned g;
      diff = gain_hi > gain_lo ? gain_hi - gain_lo : 0;
      cut = (cutoff == 0) ? 1 : cutoff;
      for (int unsigned x = 0; x < HALF_SIDE; x++) begin
        if (x <= cut) begin
          w = 32768 - cosine_q15(x, cut);
          g = gain_lo + ((longint'(diff) * w + 32768) >> 16);
          if (g > 65535) g = 65535;
          gain_lut[x] = g[15:0];
        end else begin
          gain_lut[x] = gain_lut[x - 1];
        end
      end
      lut_valid = 1;
    endfunction

    function logic [31:0] apply_gain(logic [31:0] v, logic [15:0] g);
      logic [63:0] mag, r;
      logic [31:0] negv;
      negv = -v;
      mag = v[31] ? {32'd0, negv} : {32'd0, v};
      r = (mag * g + 2048) >> 12;
      if (v[31]) begin
        if (r > 64'h8000_0000) r = 64'h8000_0000;
        return -r[31:0];
      end
      if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
      return r[31:0];
    endfunction

    function void note_coef(logic [31:0] re, logic [31:0] im);
      int unsigned s, n, half, c, r, dx, dy, rad;
      scaled_coef_t e;
      s = (side_log2 < 1) ? 1 : side_log2;
      n = 1 << s;
      while (n > MAX_SIDE) n >>= 1;
      half = n / 2;
      if (!lut_valid) build_lut();
      c = (col >= n) ? n - 1 : col;
      r = (row >= n) ? n - 1 : row;
      dx = c >= half ? c - half : half - c;
      dy = r >= half ? r - half : half - r;
      rad = $floor($sqrt(real'(dx * dx + dy * dy)));
      while (rad * rad > dx * dx + dy * dy) rad--;
      while ((rad + 1) * (rad + 1) <= dx * dx + dy * dy) rad++;
      if (rad > half - 1) rad = half - 1;
      if (rad >= HALF_SIDE) rad = HALF_SIDE - 1;
      e.re = apply_gain(re, gain_lut[rad]);
      e.im = apply_gain(im, gain_lut[rad]);
      e.last = (c == n - 1) && (r == n - 1);
      pending.push_back(e);
      if (c + 1 >= n) begin
        col = 0;
        row = (r + 1 >= n) ? 0 : r + 1;
      end else begin
        col = c + 1;
        row = r;
      end
    endfunction

    task check_beat(logic [63:0] data, logic last);
      scaled_coef_t e;
      if (pending.size() == 0) begin
        report("unexpected beat", data[31:0], 32'd0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (last) frames++;
      if (data[31:0] !== e.re) report("out_re", data[31:0], e.re);
      if (data[63:32] !== e.im) report("out_im", data[63:32], e.im);
      if (last !== e.last) report("frame_end", {31'd0, last}, {31'd0, e.last});
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = REG_GAIN_LOW;
  logic [15:0] cfg_wdata = '0;

  gain_scoreboard sb = new();
  bit          calm = 0;
  int unsigned sink_stall = 0;
  int unsigned coefs_sent = 0;

  radial_raised_cosine_spectrum_gain u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side: random stall bursts, none once calm
  always @(posedge clk) begin
    if (calm) begin
      out_tready <= 1'b1;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      sink_stall = $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tlast);
  end

  task send_coef(logic [31:0] re, logic [31:0] im);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {im, re};
    do @(posedge clk); while (!in_tready);
    sb.note_coef(re, im);
    coefs_sent++;
  endtask

  function logic [31:0] rand_part();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 4000) - 2000;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 255)
                                     : 32'h8000_0000 + $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task send_random(int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_coef(rand_part(), rand_part());
    in_tvalid <= 1'b0;
  endtask

  // drain, then let the block settle before touching registers
  task wait_drained();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task set_all(logic [15:0] lo, logic [15:0] hi, logic [15:0] cut, logic [15:0] sz);
    wait_drained();
    write_reg(REG_GAIN_LOW, lo);
    write_reg(REG_GAIN_HIGH, hi);
    write_reg(REG_CUTOFF, cut);
    write_reg(REG_SIZE_LOG2, sz);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] edge_vals [8];
    edge_vals = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                  32'h1, 32'h0000_0800, 32'hFFFF_F800, 32'h5555_AAAA};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: corner of a 256 frame sits at full high gain
    for (int i = 0; i < 8; i++) send_coef(edge_vals[i], edge_vals[7 - i]);
    send_random(180);

    // zero size maps to N=2; widest gain span, narrowest cutoff
    set_all(16'd1, 16'd65535, 16'd1, 16'd0);
    for (int i = 0; i < 8; i++) send_coef(edge_vals[i], edge_vals[(i + 3) % 8]);
    send_random(180);

    // inverted gains and a cutoff that masks to zero
    set_all(16'd65535, 16'd1, 16'h0200, 16'd2);
    send_random(180);

    set_all(16'd4096, 16'(4096 + $urandom_range(1, 20000)), 16'd7, 16'd3);
    send_random(180);

    // cutoff beyond the table end over the largest frame: radii reach the table end
    set_all(16'($urandom_range(1, 30000)), 16'($urandom_range(30000, 65535)),
            16'd256, 16'd9);
    send_random(180);

    // oversized size clamps to 512; change size mid-frame below
    set_all(16'd100, 16'd40000, 16'd20, 16'd15);
    send_random(120);
    wait_drained();
    write_reg(REG_SIZE_LOG2, 16'd1);
    cfg_we <= 1'b0;
    send_random(60);

    set_all(16'd3000, 16'd50000, 16'd3, 16'd4);
    calm = 1;
    send_random(254);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d coefficients, %0d results checked, %0d frame ends",
             coefs_sent, sb.checked, sb.frames);
    $display("seven register settings, gain and cutoff extremes, sizes 2 to 512");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS radial_raised_cosine_spectrum_gain");
    end else begin
      $display("FAIL radial_raised_cosine_spectrum_gain");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAIL radial_raised_cosine_spectrum_gain");
    $finish;
  end

endmodule

### radial_raised_cosine_spectrum_gain.f
hdl/rrcg_pkg.sv
hdl/rrcg_alu.sv
hdl/radial_raised_cosine_spectrum_gain.sv
test/tb_radial_raised_cosine_spectrum_gain.sv
